[design/scl_pkg.sv]
package scl_pkg;

  // Token kinds as they appear on the result port
  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_WORD    = 3'd1,
    KIND_PIPE    = 3'd2,
    KIND_LESS    = 3'd3,
    KIND_HEREDOC = 3'd4,
    KIND_GREATER = 3'd5,
    KIND_APPEND  = 3'd6
  } kind_t;

  localparam int TOK_POS_W = 13;
  localparam int Q_DEPTH   = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  typedef struct packed {
    kind_t                  kind;
    logic [TOK_POS_W-1:0]   start;
    logic [TOK_POS_W-1:0]   stop;
  } tok_t;

  // Everything one input item produces: one or two tokens
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

endpackage

[design/scl_front.sv]
module scl_front #(
  parameter int MAX_LINE = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take_i,
  input  logic [7:0]    char_i,
  input  logic          end_i,
  output scl_pkg::push_t push_o
);
  import scl_pkg::*;

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam logic [PW-1:0] LIMIT = PW'(MAX_LINE);

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_DQ, M_SQ, M_LT, M_GT
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [PW-1:0]  begin_r, begin_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;

  function automatic logic [PW-1:0] after_pos(input logic [PW-1:0] p);
    return (p < LIMIT) ? p + 1'b1 : LIMIT;
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [PW-1:0] a,
                                  input logic [PW-1:0] b);
    tok_t t;
    t.kind  = k;
    t.start = TOK_POS_W'(a);
    t.stop  = TOK_POS_W'(b);
    return t;
  endfunction

  logic          is_sp, is_pipe, is_brk;
  mode_t         st_mode;
  logic [PW-1:0] p, p1;
  logic          two;
  logic          any;
  tok_t          t0, t1;

  assign p  = pos_r;
  assign p1 = after_pos(pos_r);

  always_comb begin
    is_sp   = (char_i == CH_SPACE) || (char_i == CH_TAB) || (char_i == CH_CR) ||
              (char_i == CH_LF) || (char_i == CH_VT) || (char_i == CH_NUL);
    is_pipe = (char_i == CH_PIPE);
    is_brk  = is_sp || is_pipe || (char_i == CH_LT) || (char_i == CH_GT) ||
              (char_i == CH_DQ) || (char_i == CH_SQ);
    // mode a character opens when seen between tokens
    if (is_sp || is_pipe)       st_mode = M_IDLE;
    else if (char_i == CH_LT)   st_mode = M_LT;
    else if (char_i == CH_GT)   st_mode = M_GT;
    else if (char_i == CH_DQ)   st_mode = M_DQ;
    else if (char_i == CH_SQ)   st_mode = M_SQ;
    else                        st_mode = M_WORD;
  end

  always_comb begin
    any       = 1'b0;
    two       = 1'b0;
    t0        = mk_tok(KIND_END, p, p);
    t1        = mk_tok(KIND_PIPE, p, p1);
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pos_nxt   = p1;
    if (end_i) begin
      any       = 1'b1;
      t1        = mk_tok(KIND_END, p, p);
      two       = 1'b1;
      mode_nxt  = M_IDLE;
      begin_nxt = '0;
      pos_nxt   = '0;
      case (mode_r)
        M_WORD, M_DQ, M_SQ: t0 = mk_tok(KIND_WORD, begin_r, p);
        M_LT:               t0 = mk_tok(KIND_LESS, begin_r, p);
        M_GT:               t0 = mk_tok(KIND_GREATER, begin_r, p);
        default: begin
          two = 1'b0;
          t0  = mk_tok(KIND_END, p, p);
        end
      endcase
    end else begin
      case (mode_r)
        M_WORD: begin
          if (is_brk) begin
            any      = 1'b1;
            two      = is_pipe;
            t0       = mk_tok(KIND_WORD, begin_r, p);
            mode_nxt = st_mode;
            if (!is_sp && !is_pipe) begin_nxt = p;
          end
        end
        M_DQ: begin
          if (char_i == CH_DQ) begin
            any      = 1'b1;
            t0       = mk_tok(KIND_WORD, begin_r, p1);
            mode_nxt = M_IDLE;
          end
        end
        M_SQ: begin
          if (char_i == CH_SQ) begin
            any      = 1'b1;
            t0       = mk_tok(KIND_WORD, begin_r, p1);
            mode_nxt = M_IDLE;
          end
        end
        M_LT, M_GT: begin
          any = 1'b1;
          if ((mode_r == M_LT && char_i == CH_LT) ||
              (mode_r == M_GT && char_i == CH_GT)) begin
            t0 = mk_tok((mode_r == M_LT) ? KIND_HEREDOC : KIND_APPEND, begin_r, p1);
            mode_nxt = M_IDLE;
          end else begin
            t0 = mk_tok((mode_r == M_LT) ? KIND_LESS : KIND_GREATER, begin_r, p);
            two      = is_pipe;
            mode_nxt = st_mode;
            if (!is_sp && !is_pipe) begin_nxt = p;
          end
        end
        default: begin
          // between tokens: a pipe is a token by itself
          any      = is_pipe;
          t0       = mk_tok(KIND_PIPE, p, p1);
          mode_nxt = st_mode;
          if (!is_sp && !is_pipe) begin_nxt = p;
        end
      endcase
    end
  end

  assign push_o.valid  = take_i && any;
  assign push_o.rec.two = two;
  assign push_o.rec.t0  = t0;
  assign push_o.rec.t1  = t1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (take_i) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

[design/scl_queue.sv]
module scl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  scl_pkg::push_t wr_i,
  input  logic           rd_i,
  output logic           full_o,
  output logic           avail_o,
  output scl_pkg::rec_t  head_o
);
  import scl_pkg::*;

  localparam int QPW = $clog2(Q_DEPTH);
  localparam int CW  = $clog2(Q_DEPTH + 1);

  rec_t           ent_r [Q_DEPTH];
  logic [QPW-1:0] wp_r, wp_nxt;
  logic [QPW-1:0] rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full_o  = (cnt_r == CW'(Q_DEPTH));
  assign avail_o = (cnt_r != '0);
  assign head_o  = ent_r[rp_r];

  assign do_wr = wr_i.valid && !full_o;
  assign do_rd = rd_i && avail_o;

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) ent_r[wp_r] <= wr_i.rec;
  end

endmodule

[design/scl_back.sv]
module scl_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              avail_i,
  input  scl_pkg::rec_t                     head_i,
  output logic                              rd_o,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        out_token_kind,
  output logic [scl_pkg::TOK_POS_W-1:0]     out_token_start,
  output logic [scl_pkg::TOK_POS_W-1:0]     out_token_stop,
  output logic                              out_run_last
);
  import scl_pkg::*;

  logic  valid_r, valid_nxt;
  logic  sel_r, sel_nxt;
  tok_t  tok_r;
  logic  last_r;
  logic  load, take, last;
  tok_t  tok;

  assign load = !valid_r || pop;
  assign take = load && avail_i;
  assign tok  = sel_r ? head_i.t1 : head_i.t0;
  assign last = !head_i.two || sel_r;
  assign rd_o = take && last;

  always_comb begin
    valid_nxt = load ? avail_i : valid_r;
    sel_nxt   = take ? !last : sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r  <= tok;
      last_r <= last;
    end
  end

  assign empty           = !valid_r;
  assign out_token_kind  = tok_r.kind;
  assign out_token_start = tok_r.start;
  assign out_token_stop  = tok_r.stop;
  assign out_run_last    = last_r;

endmodule

[design/shell_command_lexer.sv]
// Streaming shell command-line lexer.
// Input side is a queue write port: present one character (in_char_byte) or
// an end-of-line marker (in_line_end) with push; the item is taken on a
// rising edge with push high and full low. Result side is a queue read port:
// while empty is low the oldest token (kind, start, stop, run_last) sits on
// the out_ ports, and pop on a rising edge with empty low takes it.
// Each item yields zero, one or two tokens; run_last flags the final one.
// A taken item's record is written into the queue on the edge that takes
// it; the back end then moves its tokens into the output register.
// Throughput: the front end takes one item per cycle while full is low;
// the result port drains one token per cycle while pop is high, so items
// that give two tokens hold the back end for both of them.
// The front end and the back end are parted by a four-entry record queue;
// full rises only when that queue is full, so a stalled reader holds input
// off once four items that carry tokens are waiting in the queue.
// Reset (synchronous, rst_n low) empties the queue and output register and
// returns the lexer to idle at line position zero.
module shell_command_lexer #(
  parameter int MAX_LINE = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_char_byte,
  input  logic                          in_line_end,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    out_token_kind,
  output logic [scl_pkg::TOK_POS_W-1:0] out_token_start,
  output logic [scl_pkg::TOK_POS_W-1:0] out_token_stop,
  output logic                          out_run_last
);
  import scl_pkg::*;

  push_t push_w;
  rec_t  head_w;
  logic  take;
  logic  q_rd, q_avail;

  // item taken when the record queue has room
  assign take = push && !full;

  // front: mode tracking and token classification
  scl_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (take),
    .char_i (in_char_byte),
    .end_i  (in_line_end),
    .push_o (push_w)
  );

  // decoupling queue, one record per item that produces tokens
  scl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_i    (push_w),
    .rd_i    (q_rd),
    .full_o  (full),
    .avail_o (q_avail),
    .head_o  (head_w)
  );

  // back: splits records into single tokens into the output register
  scl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .avail_i         (q_avail),
    .head_i          (head_w),
    .rd_o            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_token_kind  (out_token_kind),
    .out_token_start (out_token_start),
    .out_token_stop  (out_token_stop),
    .out_run_last    (out_run_last)
  );

endmodule
